/* rtl/swuj_pkg.sv */
// swuj_pkg: operation and error codes for the stack with undo journal
// no dependencies
`default_nettype none

package swuj_pkg;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_UNDO = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL = 2'd2;
    localparam logic [1:0] ERR_UNDO_PAST = 2'd3;

    localparam int OUT_WIDTH   = 32;
    localparam int COUNT_WIDTH = 31;

endpackage

`default_nettype wire

/* rtl/stack_with_undo_journal_core.sv */
// stack_with_undo_journal_core: signed value stack with an undo journal ring
// depends on swuj_pkg; holds the value memory and the journal memory
//
// usage: present i_kind / i_operand with start while busy is low; the beat
// is taken at that clock edge. every beat yields one result, shown for one
// cycle with o_done: o_top_value, o_is_empty and o_error.
// from the accepting edge to o_done:
//   push, rejected pop, kind 3, undo count <= 0 : o_done follows in the next cycle
//   pop that leaves the stack empty             : o_done follows in the next cycle
//   other pop                                   : via S_POP_TOP (value memory read)
//   undo : S_UNDO, S_UNDO_RD (journal read) per step, and S_UNDO_TOP (value
//   memory read for the new top) per undone push that leaves the stack nonempty
// busy stays high while an item is in work; a push stream runs one beat per
// cycle. the value and journal memories have registered synchronous reads.
// reset clears height, journal head and fill; memory contents need no
// clearing since only written entries are ever read.
// the receiver cannot stall: each result is taken in its o_done cycle, and a
// new item may be started in that same cycle.
`default_nettype none

module stack_with_undo_journal_core
    import swuj_pkg::*;
#(
    parameter int STACK_DEPTH   = 256,
    parameter int JOURNAL_DEPTH = 256,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_kind,
    input  wire logic signed [31:0]    i_operand,
    output logic                       o_done,
    output logic signed [31:0]         o_top_value,
    output logic                       o_is_empty,
    output logic [1:0]                 o_error
);

    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SHW = $clog2(STACK_DEPTH + 1);
    localparam int JAW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
    localparam int JFW = $clog2(JOURNAL_DEPTH + 1);
    localparam int JEW = VALUE_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_TOP,
        S_UNDO,
        S_UNDO_RD,
        S_UNDO_TOP
    } t_state;

    t_state                        r_state, n_state;
    logic [SHW-1:0]                r_height, n_height;
    logic [JAW-1:0]                r_head, n_head;
    logic [JFW-1:0]                r_fill, n_fill;
    logic signed [VALUE_WIDTH-1:0] r_top, n_top;
    logic [COUNT_WIDTH-1:0]        r_count, n_count;
    logic [1:0]                    r_error, n_error;
    logic                          r_done, n_done;

    logic [VALUE_WIDTH-1:0] value_mem [STACK_DEPTH];
    logic [JEW-1:0]         journal_mem [JOURNAL_DEPTH];
    logic [VALUE_WIDTH-1:0] r_vrdata;
    logic [JEW-1:0]         r_jrdata;

    logic                   vwe, jwe;
    logic [SAW-1:0]         vwaddr;
    logic [VALUE_WIDTH-1:0] vwdata;
    logic [JEW-1:0]         jwdata;
    logic [SAW-1:0]         vraddr;

    logic [SHW-1:0]         hm1, hm2;
    logic                   full;
    logic [JAW-1:0]         head_prev, head_next;
    logic signed [63:0]     op_ext, top_ext;
    logic [VALUE_WIDTH-1:0] op_val;
    logic [VALUE_WIDTH-1:0] jr_val;

    assign hm1       = r_height - SHW'(1);
    assign hm2       = r_height - SHW'(2);
    assign full      = (r_height == SHW'(STACK_DEPTH));
    assign head_prev = (r_head == '0) ? JAW'(JOURNAL_DEPTH - 1) : r_head - JAW'(1);
    assign head_next = (r_head == JAW'(JOURNAL_DEPTH - 1)) ? '0 : r_head + JAW'(1);
    assign op_ext    = 64'(i_operand);
    assign op_val    = op_ext[VALUE_WIDTH-1:0];
    assign top_ext   = 64'(r_top);
    assign jr_val    = r_jrdata[VALUE_WIDTH-1:0];
    assign vraddr    = hm2[SAW-1:0];

    always_comb begin
        n_state  = r_state;
        n_height = r_height;
        n_head   = r_head;
        n_fill   = r_fill;
        n_top    = r_top;
        n_count  = r_count;
        n_error  = r_error;
        n_done   = 1'b0;
        vwe      = 1'b0;
        vwaddr   = r_height[SAW-1:0];
        vwdata   = op_val;
        jwe      = 1'b0;
        jwdata   = {1'b0, VALUE_WIDTH'(0)};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_PUSH: begin
                            n_done  = 1'b1;
                            n_error = ERR_NONE;
                            if (full) begin
                                n_error = ERR_PUSH_FULL;
                            end else begin
                                vwe      = 1'b1;
                                n_top    = op_val;
                                n_height = r_height + SHW'(1);
                                jwe      = 1'b1;
                                n_head   = head_next;
                                if (r_fill != JFW'(JOURNAL_DEPTH)) begin
                                    n_fill = r_fill + JFW'(1);
                                end
                            end
                        end
                        KIND_POP: begin
                            n_error = ERR_NONE;
                            if (r_height == '0) begin
                                n_done  = 1'b1;
                                n_error = ERR_POP_EMPTY;
                            end else begin
                                jwe      = 1'b1;
                                jwdata   = {1'b1, r_top};
                                n_head   = head_next;
                                n_height = hm1;
                                if (r_fill != JFW'(JOURNAL_DEPTH)) begin
                                    n_fill = r_fill + JFW'(1);
                                end
                                if (hm1 == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_state = S_POP_TOP;
                                end
                            end
                        end
                        KIND_UNDO: begin
                            n_error = ERR_NONE;
                            if (!i_operand[31] && i_operand != '0) begin
                                n_count = i_operand[COUNT_WIDTH-1:0];
                                n_state = S_UNDO;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_error = ERR_NONE;
                        end
                    endcase
                end
            end
            S_POP_TOP: begin
                n_top   = r_vrdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_UNDO: begin
                if (r_count == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_fill == '0) begin
                    n_done  = 1'b1;
                    n_error = ERR_UNDO_PAST;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UNDO_RD;
                end
            end
            S_UNDO_RD: begin
                if (r_jrdata[VALUE_WIDTH]) begin
                    if (full) begin
                        n_done  = 1'b1;
                        n_error = ERR_UNDO_PAST;
                        n_state = S_IDLE;
                    end else begin
                        vwe      = 1'b1;
                        vwdata   = jr_val;
                        n_top    = jr_val;
                        n_height = r_height + SHW'(1);
                        n_head   = head_prev;
                        n_fill   = r_fill - JFW'(1);
                        n_count  = r_count - COUNT_WIDTH'(1);
                        n_state  = S_UNDO;
                    end
                end else begin
                    if (r_height == '0) begin
                        n_done  = 1'b1;
                        n_error = ERR_UNDO_PAST;
                        n_state = S_IDLE;
                    end else begin
                        n_height = hm1;
                        n_head   = head_prev;
                        n_fill   = r_fill - JFW'(1);
                        n_count  = r_count - COUNT_WIDTH'(1);
                        n_state  = (hm1 == '0) ? S_UNDO : S_UNDO_TOP;
                    end
                end
            end
            S_UNDO_TOP: begin
                n_top   = r_vrdata;
                n_state = S_UNDO;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_height <= '0;
            r_head   <= '0;
            r_fill   <= '0;
            r_done   <= 1'b0;
            r_error  <= ERR_NONE;
        end else begin
            r_state  <= n_state;
            r_height <= n_height;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_done   <= n_done;
            r_error  <= n_error;
        end
        r_top   <= n_top;
        r_count <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            value_mem[vwaddr] <= vwdata;
        end
        r_vrdata <= value_mem[vraddr];
    end

    always_ff @(posedge i_clk) begin
        if (jwe) begin
            journal_mem[r_head] <= jwdata;
        end
        r_jrdata <= journal_mem[head_prev];
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_is_empty  = (r_height == '0);
    assign o_top_value = (r_height == '0) ? 32'sd0 : top_ext[OUT_WIDTH-1:0];
    assign o_error     = r_error;

    a_push_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_PUSH) |=> o_done)
        else $error("push did not complete in one cycle");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error == ERR_POP_EMPTY) |-> o_is_empty)
        else $error("pop on empty reported a nonempty stack");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error == ERR_PUSH_FULL) |-> (r_height == SHW'(STACK_DEPTH)))
        else $error("push full reported without a full stack");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= JFW'(JOURNAL_DEPTH)) && (r_height <= SHW'(STACK_DEPTH)))
        else $error("journal fill or stack height out of range");

endmodule

`default_nettype wire

/* tb/tb_stack_with_undo_journal_core.sv */
// tb_stack_with_undo_journal_core: self-checking bench for the undo-journal stack core
// depends on swuj_pkg and stack_with_undo_journal_core; a built-in stack/journal
// predictor checks every o_done beat against the oldest expected result
module tb_stack_with_undo_journal_core
    import swuj_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_SLOTS   = 256;
    localparam int JOURNAL_SLOTS = 256;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic signed [31:0] top;
        logic               empty;
        logic [1:0]         err;
    } t_stack_view;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_kind;
    logic signed [31:0] i_operand;
    logic               o_done;
    logic signed [31:0] o_top_value;
    logic               o_is_empty;
    logic [1:0]         o_error;

    logic [31:0] held_vals [STACK_SLOTS];
    int          held_count;
    logic [32:0] undo_log [JOURNAL_SLOTS];
    logic [7:0]  log_head;
    int          log_count;

    t_stack_view pending_views[$];
    int          fail_count;
    int          burst_left;

    stack_with_undo_journal_core #(
        .STACK_DEPTH   (STACK_SLOTS),
        .JOURNAL_DEPTH (JOURNAL_SLOTS),
        .VALUE_WIDTH   (32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_operand   (i_operand),
        .o_done      (o_done),
        .o_top_value (o_top_value),
        .o_is_empty  (o_is_empty),
        .o_error     (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("FAIL stack_with_undo_journal_core");
        $finish;
    end

    function automatic void journal_record(logic [32:0] entry);
        undo_log[log_head] = entry;
        log_head = log_head + 8'd1;
        if (log_count < JOURNAL_SLOTS) begin
            log_count++;
        end
    endfunction

    function automatic bit journal_unwind_one();
        logic [7:0]  slot;
        logic [32:0] entry;
        if (log_count == 0) begin
            return 1'b0;
        end
        slot = log_head - 8'd1;
        entry = undo_log[slot];
        if (entry[32]) begin
            if (held_count >= STACK_SLOTS) begin
                return 1'b0;
            end
            held_vals[held_count] = entry[31:0];
            held_count++;
        end else begin
            if (held_count == 0) begin
                return 1'b0;
            end
            held_count--;
        end
        log_head = slot;
        log_count--;
        return 1'b1;
    endfunction

    function automatic t_stack_view stack_apply(logic [1:0] kind, logic signed [31:0] operand);
        t_stack_view view;
        int unsigned steps;
        view.err = ERR_NONE;
        case (kind)
            KIND_PUSH: begin
                if (held_count >= STACK_SLOTS) begin
                    view.err = ERR_PUSH_FULL;
                end else begin
                    held_vals[held_count] = operand;
                    held_count++;
                    journal_record(33'd0);
                end
            end
            KIND_POP: begin
                if (held_count == 0) begin
                    view.err = ERR_POP_EMPTY;
                end else begin
                    held_count--;
                    journal_record({1'b1, held_vals[held_count]});
                end
            end
            KIND_UNDO: begin
                if (operand > 0) begin
                    steps = operand;
                    while (steps > 0) begin
                        if (!journal_unwind_one()) begin
                            view.err = ERR_UNDO_PAST;
                            break;
                        end
                        steps--;
                    end
                end
            end
            default: ;
        endcase
        if (held_count == 0) begin
            view.top = '0;
            view.empty = 1'b1;
        end else begin
            view.top = held_vals[held_count - 1];
            view.empty = 1'b0;
        end
        return view;
    endfunction

    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // one beat: idle, raise start, hold until taken, then record what it should return
    task automatic send_item(logic [1:0] kind, logic signed [31:0] operand);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_operand <= operand;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_views.insert(pending_views.size(), stack_apply(kind, operand));
    endtask

    always @(posedge i_clk) begin
        t_stack_view want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_views.size() == 0) begin
                $display("%0t: result beat with nothing expected: top %h empty %b error %0d",
                         $time, o_top_value, o_is_empty, o_error);
                fail_count++;
            end else begin
                want = pending_views.pop_front();
                if (o_top_value !== want.top) begin
                    $display("%0t: top_value expected %h, got %h", $time, want.top, o_top_value);
                    fail_count++;
                end
                if (o_is_empty !== want.empty) begin
                    $display("%0t: is_empty expected %b, got %b", $time, want.empty, o_is_empty);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $display("%0t: error expected %0d, got %0d", $time, want.err, o_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_edge_cases();
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_UNDO, 32'sd1);
        send_item(KIND_UNDO, 32'sd0);
        send_item(KIND_UNDO, -32'sd1);
        send_item(KIND_UNDO, 32'sh8000_0000);
        send_item(KIND_UNUSED, 32'shFFFF_FFFF);
        send_item(KIND_PUSH, 32'sh7FFF_FFFF);
        send_item(KIND_PUSH, 32'sh8000_0000);
        send_item(KIND_PUSH, 32'sd0);
        send_item(KIND_PUSH, -32'sd1);
        send_item(KIND_UNUSED, 32'sd0);
        send_item(KIND_POP, 32'shFFFF_FFFF);
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_UNDO, 32'sd1);
        send_item(KIND_UNDO, 32'sd2);
        send_item(KIND_UNDO, 32'sh7FFF_FFFF);
        send_item(KIND_PUSH, 32'sh5555_5555);
        send_item(KIND_PUSH, 32'shAAAA_AAAA);
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_UNDO, 32'sd2);
        send_item(KIND_UNDO, 32'sd5);
    endtask

    // fill to the brim, overrun, drain past empty, wrap the journal and replay it
    task automatic test_fill_and_wrap();
        while (held_count < STACK_SLOTS) begin
            send_item(KIND_PUSH, $urandom);
        end
        send_item(KIND_PUSH, $urandom);
        send_item(KIND_UNDO, 32'sd3);
        repeat (3) send_item(KIND_PUSH, $urandom);
        while (held_count > 0) begin
            send_item(KIND_POP, $urandom);
        end
        send_item(KIND_POP, $urandom);
        send_item(KIND_UNDO, 32'sh7FFF_FFFF);
        send_item(KIND_PUSH, $urandom);
        while (held_count > 0) begin
            send_item(KIND_POP, $urandom);
        end
    endtask

    function automatic logic signed [31:0] draw_undo_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return 32'sd0;
        end else if (pick < 12) begin
            return $urandom | 32'h8000_0000;
        end else if (pick < 22) begin
            return $urandom_range(7, 300);
        end else if (pick < 26) begin
            return $urandom & 32'h7FFF_FFFF;
        end
        return $urandom_range(1, 6);
    endfunction

    task automatic test_random_traffic(int count);
        int phase_left;
        int push_pct;
        int pick;
        phase_left = 0;
        push_pct = 50;
        repeat (count) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 300);
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_item(KIND_UNUSED, $urandom);
            end else if (pick < 13) begin
                send_item(KIND_UNDO, draw_undo_count());
            end else if ($urandom_range(0, 99) < push_pct) begin
                send_item(KIND_PUSH, $urandom);
            end else begin
                send_item(KIND_POP, $urandom);
            end
        end
    endtask

    initial begin
        held_count = 0;
        log_head = '0;
        log_count = 0;
        fail_count = 0;
        burst_left = 0;
        start <= 1'b0;
        i_kind <= KIND_PUSH;
        i_operand <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_fill_and_wrap();
        test_random_traffic(1100);

        start <= 1'b0;
        while (pending_views.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS stack_with_undo_journal_core");
        end else begin
            $display("FAIL stack_with_undo_journal_core");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/swuj_pkg.sv
rtl/stack_with_undo_journal_core.sv
tb/tb_stack_with_undo_journal_core.sv
